[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, ignored while reset is asserted.
`define POL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define POL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/pol_pkg.sv]
package pol_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int OPC_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int ENTRY_W  = 5;
    localparam int STAT_W   = 2;

    // Width used to compare a position against the count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } req_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  removed_value;
        logic        [ENTRY_W-1:0] entry_count;
    } rsp_item_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic        [IDX_W-1:0]   idx;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

[hw/rtl/pol_cell.sv]
module pol_cell
(
    input  logic                              clk,
    input  logic [pol_pkg::IDX_W-1:0]         cell_idx,
    input  pol_pkg::cell_cmd_t                cmd,
    input  logic signed [pol_pkg::DATA_W-1:0] left_data,
    input  logic signed [pol_pkg::DATA_W-1:0] right_data,
    output logic signed [pol_pkg::DATA_W-1:0] data
);
    import pol_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Insert: slot takes the new value, slots behind it take the left neighbor.
    // Delete: slots from the hole onward take the right neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (cell_idx == cmd.idx)
            begin
                data_next = cmd.value;
            end
            else if (cell_idx > cmd.idx)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.del && (cell_idx >= cmd.idx))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hw/rtl/pol_outbuf.sv]
`include "assert_macros.svh"

module pol_outbuf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pol_pkg::rsp_item_t result,
    output logic               busy,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pol_pkg::rsp_item_t rsp
);
    import pol_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    rsp_item_t out_reg;
    rsp_item_t out_next;
    rsp_item_t skid_reg;
    rsp_item_t skid_next;

    // Output stage refills from the skid first, then from a fresh result
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || rsp_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign busy      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // A parked result always has one ahead of it in the output stage
    `POL_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid holds data with output empty")

endmodule

[hw/rtl/positional_ordered_list.sv]
// Each accepted result is registered in the output stage (or the skid stage while rsp stalls) and driven on rsp.
// Throughput: one request per cycle while rsp is taken; every cell of the
// chain shifts in the same cycle, so an operation never iterates.
// A stalled output parks one more result in a skid stage, then req_ready drops.
// Reset (rst_n, async, active low) empties the list; cell contents are not cleared.
`include "assert_macros.svh"

module positional_ordered_list
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pol_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pol_pkg::rsp_item_t rsp
);
    import pol_pkg::*;

    logic                     accept;
    logic                     busy;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     full;
    logic                     empty;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     ins_ok;
    logic                     del_ok;
    logic [IDX_W-1:0]         op_idx;
    status_t                  status;
    logic signed [DATA_W-1:0] removed;
    cell_cmd_t                cmd;
    rsp_item_t                result;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign accept  = req_valid && req_ready;
    assign req_ready = !busy;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);

    // Opcode decode and range checks
    always_comb
    begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        op_idx = '0;
        status = ST_DONE;
        unique case (req.opcode) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (req.opcode == OP_INS_FRONT)
                begin
                    ins_ok = 1'b1;
                end
                else if (req.opcode == OP_INS_BACK)
                begin
                    ins_ok = 1'b1;
                    op_idx = IDX_W'(count_reg);
                end
                else if (pos_ext > cnt_ext)
                begin
                    status = ST_BAD;
                end
                else
                begin
                    ins_ok = 1'b1;
                    op_idx = IDX_W'(pos_ext);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS:
            begin
                if (empty)
                begin
                    status = ST_BAD;
                end
                else if (req.opcode == OP_DEL_FRONT)
                begin
                    del_ok = 1'b1;
                end
                else if (req.opcode == OP_DEL_BACK)
                begin
                    del_ok = 1'b1;
                    op_idx = IDX_W'(count_reg - CNT_W'(1));
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status = ST_BAD;
                end
                else
                begin
                    del_ok = 1'b1;
                    op_idx = IDX_W'(pos_ext);
                end
            end
            default:
            begin
                status = ST_BAD;
            end
        endcase
    end

    // Broadcast to the chain, count update and result
    always_comb
    begin
        cmd.ins   = accept && ins_ok;
        cmd.del   = accept && del_ok;
        cmd.idx   = op_idx;
        cmd.value = req.value;

        removed = del_ok ? cell_data[op_idx] : '0;

        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        result.status        = status;
        result.removed_value = removed;
        result.entry_count   = ENTRY_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Chain of storage cells, each wired to its neighbors; the end cells see zero beyond the chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pol_cell u_cell
        (
            .clk        (clk),
            .cell_idx   (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    pol_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `POL_ASSERT(a_count_in_range, count_reg <= CNT_W'(CAPACITY), "element count above capacity")
    `POL_ASSERT(a_ins_grows, (accept && ins_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "insert did not grow list")
    `POL_ASSERT(a_fail_keeps, (accept && (status != ST_DONE)) |=> $stable(count_reg), "failed op changed count")

endmodule
